[hdl/stes_pkg.sv]
// ----------------------------------------------------------------------------
// stes_pkg - shared types and constants of the serial time entry sequencer
// Command, event and phase codes, character constants, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package stes_pkg;

	// input command codes (s_tuser)
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result event codes (m_tuser)
	localparam logic [2:0] EV_STARTED  = 3'd0;
	localparam logic [2:0] EV_ACCEPTED = 3'd1;
	localparam logic [2:0] EV_INVALID  = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_ABORTED  = 3'd4;
	localparam logic [2:0] EV_COMPLETE = 3'd5;

	// requested field codes
	localparam logic [1:0] STEP_HOURS   = 2'd0;
	localparam logic [1:0] STEP_MINUTES = 2'd1;
	localparam logic [1:0] STEP_SECONDS = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
	localparam logic [1:0] REG_MAX_RETRIES   = 2'd1;

	// characters and limits
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [6:0] VALUE_MAX  = 7'd127;
	localparam logic [6:0] HOURS_MAX  = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;
	localparam logic [3:0] RETRY_SAT  = 4'd15;
	localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
	localparam logic [3:0]  RETRIES_RESET = 4'd3;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_HOURS   = 4'b0010,
		PH_MINUTES = 4'b0100,
		PH_SECONDS = 4'b1000
	} phase_t;

	// sequencer to line assembler
	typedef struct packed {
		logic byte_en;  // byte word taken during an active session
		logic start;    // session start, clear the line
	} line_ctrl_t;

	// line assembler to sequencer
	typedef struct packed {
		logic       line_end;  // CR or LF closing a line with digits
		logic [6:0] value;     // saturated line value
	} line_stat_t;

endpackage

`default_nettype wire

[hdl/stes_line.sv]
// ----------------------------------------------------------------------------
// stes_line - decimal line assembler
// Collects digits into a saturating value and flags a completed line.
// ----------------------------------------------------------------------------
`default_nettype none

module stes_line #(
	parameter int LINE_BYTES = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire stes_pkg::line_ctrl_t ctrl,
	input  wire  [7:0]           rx_data,
	output stes_pkg::line_stat_t stat
);

	localparam int CNT_W = $clog2(LINE_BYTES);

	logic [CNT_W-1:0] digit_count_q;
	logic [6:0]       line_value_q;

	logic        is_eol;
	logic        is_ctrl;
	logic        is_digit;
	logic [3:0]  digit;
	logic [10:0] acc;

	assign is_eol   = (rx_data == stes_pkg::CHAR_LF) || (rx_data == stes_pkg::CHAR_CR);
	assign is_ctrl  = rx_data < stes_pkg::CHAR_SPACE;
	assign is_digit = (rx_data >= stes_pkg::CHAR_ZERO) && (rx_data <= stes_pkg::CHAR_NINE);
	assign digit    = 4'(rx_data - stes_pkg::CHAR_ZERO);
	// value * 10 + digit
	assign acc = {1'b0, line_value_q, 3'b000} + {3'b000, line_value_q, 1'b0} + {7'd0, digit};

	assign stat.line_end = ctrl.byte_en && is_eol && (digit_count_q != '0);
	assign stat.value    = line_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			line_value_q  <= '0;
		end else if (ctrl.start || stat.line_end) begin
			digit_count_q <= '0;
			line_value_q  <= '0;
		end else if (ctrl.byte_en && !is_ctrl) begin
			if (is_digit) begin
				if (digit_count_q < CNT_W'(LINE_BYTES - 1)) begin
					line_value_q  <= (acc > {4'd0, stes_pkg::VALUE_MAX}) ?
					                 stes_pkg::VALUE_MAX : acc[6:0];
					digit_count_q <= digit_count_q + CNT_W'(1);
				end else begin
					// overlong line: restart at this digit
					line_value_q  <= {3'd0, digit};
					digit_count_q <= CNT_W'(1);
				end
			end else begin
				digit_count_q <= '0;
				line_value_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/serial_time_entry_sequencer.sv]
// ----------------------------------------------------------------------------
// serial_time_entry_sequencer - serial time entry session controller
// Runs an hours / minutes / seconds entry dialog over received bytes and ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one command word per transfer: start, a
//   received byte or one time tick (kind in s_tuser). Master stream (m_*)
//   carries at most one event word per command: started, accepted, invalid,
//   timeout retry, aborted or complete (kind in m_tuser).
//   The cfg channel writes timeout_ticks (index 0) and max_retries
//   (index 1); it is always ready and should be used while the block is idle.
//   An event word appears on m_* the cycle after the command word is
//   taken. Throughput is one command word per cycle, set by
//   the single result register; s_tready drops only while that register
//   holds a word the receiver has not taken, so a stalled receiver stalls
//   the input directly.
//   Reset clears the session to idle, the registers to 10000 ticks and
//   3 retries, and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_time_entry_sequencer #(
	parameter int LINE_BYTES = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// command stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [0] advanced, [8:1] rx_data, rest zero
	input  wire  [1:0]  s_tuser,   // [1:0] cmd
	// event stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [1:0] step, [5:2] retries, [11:6] entered,
	                               // [16:12] hours_out, [22:17] minutes_out,
	                               // [28:23] seconds_out, rest zero
	output logic [2:0]  m_tuser,   // [2:0] event_res
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	// configuration
	logic [15:0] timeout_ticks_q;
	logic [3:0]  max_retries_q;

	// session state
	stes_pkg::phase_t phase_q, phase_d;
	logic        mode_adv_q, mode_adv_d;
	logic [3:0]  retry_q, retry_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [4:0]  saved_hours_q, saved_hours_d;
	logic [5:0]  saved_minutes_q, saved_minutes_d;

	// result register
	logic        m_valid_q;
	logic [2:0]  ev_q;
	logic [1:0]  step_q;
	logic [3:0]  retries_q;
	logic [5:0]  entered_q;
	logic [4:0]  hours_q;
	logic [5:0]  minutes_q, seconds_q;

	// next result
	logic        emit;
	logic [2:0]  ev_d;
	logic [1:0]  step_d;
	logic [5:0]  entered_d;
	logic [4:0]  hours_d;
	logic [5:0]  minutes_d, seconds_d;

	logic        take;
	logic [1:0]  cmd;
	logic        adv;
	logic [7:0]  rx_data;
	logic        active;
	logic [1:0]  cur_step;
	logic [15:0] elapsed_inc;
	logic [3:0]  retry_inc;
	logic [6:0]  limit;

	stes_pkg::line_ctrl_t line_ctrl;
	stes_pkg::line_stat_t line_stat;

	assign take      = s_tvalid && s_tready;
	assign s_tready  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign cmd       = s_tuser;
	assign adv       = s_tdata[0];
	assign rx_data   = s_tdata[8:1];
	assign active    = phase_q != stes_pkg::PH_IDLE;

	assign line_ctrl.byte_en = take && active && (cmd == stes_pkg::CMD_BYTE);
	assign line_ctrl.start   = take && (cmd == stes_pkg::CMD_START);

	stes_line #(
		.LINE_BYTES(LINE_BYTES)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (line_ctrl),
		.rx_data(rx_data),
		.stat   (line_stat)
	);

	always_comb begin
		unique case (phase_q)
			stes_pkg::PH_MINUTES: cur_step = stes_pkg::STEP_MINUTES;
			stes_pkg::PH_SECONDS: cur_step = stes_pkg::STEP_SECONDS;
			default:              cur_step = stes_pkg::STEP_HOURS;
		endcase
	end

	assign elapsed_inc = (elapsed_q < stes_pkg::ELAPSED_SAT) ? elapsed_q + 16'd1 : elapsed_q;
	assign retry_inc   = (retry_q < stes_pkg::RETRY_SAT) ? retry_q + 4'd1 : retry_q;
	assign limit       = (phase_q == stes_pkg::PH_HOURS) ? stes_pkg::HOURS_MAX
	                                                     : stes_pkg::MINSEC_MAX;

	always_comb begin
		phase_d         = phase_q;
		mode_adv_d      = mode_adv_q;
		retry_d         = retry_q;
		elapsed_d       = elapsed_q;
		saved_hours_d   = saved_hours_q;
		saved_minutes_d = saved_minutes_q;
		emit            = 1'b0;
		ev_d            = stes_pkg::EV_STARTED;
		step_d          = cur_step;
		entered_d       = '0;
		hours_d         = '0;
		minutes_d       = '0;
		seconds_d       = '0;
		if (take) begin
			priority if (cmd == stes_pkg::CMD_START) begin
				mode_adv_d = adv;
				retry_d    = '0;
				elapsed_d  = '0;
				phase_d    = stes_pkg::PH_HOURS;
				emit       = 1'b1;
				ev_d       = stes_pkg::EV_STARTED;
				step_d     = stes_pkg::STEP_HOURS;
			end else if (!active) begin
				// byte or tick while idle: drop
			end else if (line_stat.line_end) begin
				emit      = 1'b1;
				elapsed_d = '0;
				if (mode_adv_q) begin
					retry_d = '0;
				end
				if (line_stat.value > limit) begin
					ev_d = stes_pkg::EV_INVALID;
				end else begin
					unique case (phase_q)
						stes_pkg::PH_HOURS: begin
							saved_hours_d = line_stat.value[4:0];
							phase_d       = stes_pkg::PH_MINUTES;
							retry_d       = '0;
							ev_d          = stes_pkg::EV_ACCEPTED;
							step_d        = stes_pkg::STEP_MINUTES;
							entered_d     = line_stat.value[5:0];
						end
						stes_pkg::PH_MINUTES: begin
							saved_minutes_d = line_stat.value[5:0];
							phase_d         = stes_pkg::PH_SECONDS;
							retry_d         = '0;
							ev_d            = stes_pkg::EV_ACCEPTED;
							step_d          = stes_pkg::STEP_SECONDS;
							entered_d       = line_stat.value[5:0];
						end
						default: begin
							phase_d   = stes_pkg::PH_IDLE;
							ev_d      = stes_pkg::EV_COMPLETE;
							step_d    = stes_pkg::STEP_SECONDS;
							entered_d = line_stat.value[5:0];
							hours_d   = saved_hours_q;
							minutes_d = saved_minutes_q;
							seconds_d = line_stat.value[5:0];
						end
					endcase
				end
			end else if (cmd == stes_pkg::CMD_TICK) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= timeout_ticks_q) begin
					emit = 1'b1;
					if (retry_inc >= max_retries_q) begin
						phase_d = stes_pkg::PH_IDLE;
						retry_d = '0;
						ev_d    = stes_pkg::EV_ABORTED;
					end else begin
						retry_d   = retry_inc;
						elapsed_d = '0;
						ev_d      = stes_pkg::EV_TIMEOUT;
					end
				end
			end else begin
				// digit, stray byte or unused command: no event
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= stes_pkg::TIMEOUT_RESET;
			max_retries_q   <= stes_pkg::RETRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				stes_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				stes_pkg::REG_MAX_RETRIES:   max_retries_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= stes_pkg::PH_IDLE;
			mode_adv_q      <= 1'b0;
			retry_q         <= '0;
			elapsed_q       <= '0;
			saved_hours_q   <= '0;
			saved_minutes_q <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			phase_q         <= phase_d;
			mode_adv_q      <= mode_adv_d;
			retry_q         <= retry_d;
			elapsed_q       <= elapsed_d;
			saved_hours_q   <= saved_hours_d;
			saved_minutes_q <= saved_minutes_d;
			if (take && emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload: load on a new event word only
	always_ff @(posedge clk) begin
		if (take && emit) begin
			ev_q      <= ev_d;
			step_q    <= step_d;
			retries_q <= retry_d;
			entered_q <= entered_d;
			hours_q   <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {3'd0, seconds_q, minutes_q, hours_q, entered_q, retries_q, step_q};

	// a start word always produces a started event next cycle
	a_start_event: assert property (@(posedge clk) disable iff (!arst_n)
		take && (cmd == stes_pkg::CMD_START) |=>
			m_valid_q && (ev_q == stes_pkg::EV_STARTED) && (retries_q == 4'd0))
		else $error("start word did not produce a started event");

	// only accepted and complete events carry an entered value
	a_entered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (ev_q != stes_pkg::EV_ACCEPTED) && (ev_q != stes_pkg::EV_COMPLETE) |->
			(entered_q == 6'd0))
		else $error("entered value on a non-accepting event");

	// complete returns to idle and reports in-range hours and seconds
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && (ev_d == stes_pkg::EV_COMPLETE) |=>
			(phase_q == stes_pkg::PH_IDLE) && (hours_q <= 5'd23) && (seconds_q <= 6'd59))
		else $error("complete event with bad state or time");

endmodule

`default_nettype wire
